FILE: hdl/vau_pkg.sv
// shared types, command codes and helpers of the vector arithmetic unit
package vau_pkg;

  localparam int unsigned SQ_STAGES = 32;
  localparam logic [31:0] FX_MAX = 32'h7fff_ffff;
  localparam logic [31:0] FX_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_SADD  = 4'd4,
    CMD_SSUB  = 4'd5,
    CMD_SMUL  = 4'd6,
    CMD_SDIV  = 4'd7,
    CMD_DOT   = 4'd8,
    CMD_CROSS = 4'd9,
    CMD_LEN   = 4'd10,
    CMD_NORM  = 4'd11
  } cmd_e;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             sat;
  } res_t;

  typedef struct packed {
    res_t             res;
    logic [2:0][31:0] a;
    logic [2:0][31:0] dvs;
    logic [2:0]       neg;
    logic             use_div;
    logic             is_len;
    logic             is_norm;
  } carry_t;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

FILE: hdl/vau_front.sv
// input, multiplier, sum and clamp stages of the vector arithmetic unit
module vau_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [3:0]       command_i,
  input  logic [2:0][31:0] a_i,
  input  logic [2:0][31:0] b_i,
  input  logic [31:0]      s_i,
  output logic             valid_o,
  output vau_pkg::carry_t  carry_o,
  output logic [63:0]      rad_o
);
  import vau_pkg::*;

  localparam logic signed [65:0] MAX66 = 66'sd2147483647;
  localparam logic signed [65:0] MIN66 = -66'sd2147483648;

  function automatic logic signed [65:0] sx32(input logic [31:0] x);
    return $signed({{34{x[31]}}, x});
  endfunction

  function automatic logic signed [65:0] sx64(input logic [63:0] x);
    return $signed({{2{x[63]}}, x});
  endfunction

  // stage 0
  logic             v0_q;
  cmd_e             cmd0_q;
  logic [2:0][31:0] a0_q, b0_q;
  logic [31:0]      s0_q;

  // stage 1
  logic             v1_q;
  cmd_e             cmd1_q;
  logic [2:0][31:0] a1_q, b1_q;
  logic [31:0]      s1_q;
  logic [5:0][31:0] mx, my;
  logic [5:0][63:0] p1_q;

  // stage 2
  logic               v2_q;
  cmd_e               cmd2_q;
  logic signed [65:0] t_d [3];
  logic signed [65:0] t2_q [3];
  logic               shf_d, shf2_q;
  logic [2:0][31:0]   a2_q, dvs_d, dvs2_q;
  logic [2:0]         neg_d, neg2_q;
  logic               use_d, use2_q;

  // stage 3
  logic               v3_q;
  logic signed [65:0] u [3];
  logic [2:0]         ov, un;
  logic [2:0][31:0]   c;
  carry_t             carry_d, carry_q;
  logic [63:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd0_q <= cmd_e'(command_i);
      a0_q   <= a_i;
      b0_q   <= b_i;
      s0_q   <= s_i;
    end
  end

  always_comb begin
    mx = '0;
    my = '0;
    case (cmd0_q)
      CMD_CROSS: begin
        mx[0] = a0_q[1]; my[0] = b0_q[2];
        mx[1] = a0_q[2]; my[1] = b0_q[1];
        mx[2] = a0_q[2]; my[2] = b0_q[0];
        mx[3] = a0_q[0]; my[3] = b0_q[2];
        mx[4] = a0_q[0]; my[4] = b0_q[1];
        mx[5] = a0_q[1]; my[5] = b0_q[0];
      end
      CMD_LEN, CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = a0_q[i];
          my[i] = a0_q[i];
        end
      end
      CMD_SMUL: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = a0_q[i];
          my[i] = s0_q;
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = a0_q[i];
          my[i] = b0_q[i];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q <= cmd0_q;
      a1_q   <= a0_q;
      b1_q   <= b0_q;
      s1_q   <= s0_q;
      for (int k = 0; k < 6; k++) begin
        p1_q[k] <= $signed({{32{mx[k][31]}}, mx[k]}) * $signed({{32{my[k][31]}}, my[k]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) t_d[i] = '0;
    shf_d = 1'b0;
    case (cmd1_q)
      CMD_ADD:  for (int i = 0; i < 3; i++) t_d[i] = sx32(a1_q[i]) + sx32(b1_q[i]);
      CMD_SUB:  for (int i = 0; i < 3; i++) t_d[i] = sx32(a1_q[i]) - sx32(b1_q[i]);
      CMD_SADD: for (int i = 0; i < 3; i++) t_d[i] = sx32(a1_q[i]) + sx32(s1_q);
      CMD_SSUB: for (int i = 0; i < 3; i++) t_d[i] = sx32(a1_q[i]) - sx32(s1_q);
      CMD_MUL, CMD_SMUL: begin
        for (int i = 0; i < 3; i++) t_d[i] = sx64(p1_q[i]);
        shf_d = 1'b1;
      end
      CMD_DOT: begin
        t_d[0] = sx64(p1_q[0]) + sx64(p1_q[1]) + sx64(p1_q[2]);
        shf_d  = 1'b1;
      end
      CMD_CROSS: begin
        t_d[0] = sx64(p1_q[0]) - sx64(p1_q[1]);
        t_d[1] = sx64(p1_q[2]) - sx64(p1_q[3]);
        t_d[2] = sx64(p1_q[4]) - sx64(p1_q[5]);
        shf_d  = 1'b1;
      end
      CMD_LEN, CMD_NORM: t_d[0] = sx64(p1_q[0]) + sx64(p1_q[1]) + sx64(p1_q[2]);
      CMD_DIV, CMD_SDIV: for (int i = 0; i < 3; i++) t_d[i] = sx32(a1_q[i]);
      default: ;
    endcase

    for (int i = 0; i < 3; i++) begin
      dvs_d[i] = (cmd1_q == CMD_DIV) ? abs32(b1_q[i]) : abs32(s1_q);
      neg_d[i] = a1_q[i][31] ^ ((cmd1_q == CMD_DIV)  ? b1_q[i][31] :
                                (cmd1_q == CMD_SDIV) ? s1_q[31] : 1'b0);
    end
    use_d = ((cmd1_q == CMD_DIV) && (b1_q[0] != '0) && (b1_q[1] != '0) && (b1_q[2] != '0))
         || ((cmd1_q == CMD_SDIV) && (s1_q != '0));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd2_q <= cmd1_q;
      t2_q   <= t_d;
      shf2_q <= shf_d;
      a2_q   <= a1_q;
      dvs2_q <= dvs_d;
      neg2_q <= neg_d;
      use2_q <= use_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i]  = shf2_q ? (t2_q[i] >>> FRAC_BITS) : t2_q[i];
      ov[i] = u[i] > MAX66;
      un[i] = u[i] < MIN66;
      c[i]  = ov[i] ? FX_MAX : un[i] ? FX_MIN : u[i][31:0];
    end
    carry_d.a       = a2_q;
    carry_d.dvs     = dvs2_q;
    carry_d.neg     = neg2_q;
    carry_d.use_div = use2_q;
    carry_d.is_len  = (cmd2_q == CMD_LEN);
    carry_d.is_norm = (cmd2_q == CMD_NORM);
    case (cmd2_q)
      CMD_DOT: begin
        carry_d.res.r   = '0;
        carry_d.res.sc  = c[0];
        carry_d.res.sat = ov[0] | un[0];
      end
      CMD_LEN, CMD_NORM: begin
        carry_d.res = '0;
      end
      default: begin
        carry_d.res.r   = c;
        carry_d.res.sc  = '0;
        carry_d.res.sat = |(ov | un);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      carry_q <= carry_d;
      rad_q   <= t2_q[0][63:0];
    end
  end

  assign valid_o = v3_q;
  assign carry_o = carry_q;
  assign rad_o   = rad_q;

endmodule

FILE: hdl/vau_sqrt.sv
// pipelined integer square root, one root bit per stage
module vau_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  vau_pkg::carry_t carry_i,
  input  logic [63:0]     rad_i,
  output logic            valid_o,
  output vau_pkg::carry_t carry_o,
  output logic [31:0]     root_o
);
  import vau_pkg::*;

  logic        v_q    [SQ_STAGES];
  carry_t      c_q    [SQ_STAGES];
  logic [63:0] rad_q  [SQ_STAGES];
  logic [32:0] rem_q  [SQ_STAGES];
  logic [31:0] root_q [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic        vi;
    carry_t      ci;
    logic [63:0] ri;
    logic [32:0] mi;
    logic [31:0] qi;
    logic [34:0] rt, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vi = valid_i;
      assign ci = carry_i;
      assign ri = rad_i;
      assign mi = '0;
      assign qi = '0;
    end else begin : g_next
      assign vi = v_q[k-1];
      assign ci = c_q[k-1];
      assign ri = rad_q[k-1];
      assign mi = rem_q[k-1];
      assign qi = root_q[k-1];
    end

    assign rt    = {mi, ri[63:62]};
    assign trial = {1'b0, qi, 2'b01};
    assign ge    = rt >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k]    <= ci;
        rad_q[k]  <= {ri[61:0], 2'b00};
        rem_q[k]  <= ge ? 33'(rt - trial) : rt[32:0];
        root_q[k] <= {qi[30:0], ge};
      end
    end
  end

  assign valid_o = v_q[SQ_STAGES-1];
  assign carry_o = c_q[SQ_STAGES-1];
  assign root_o  = root_q[SQ_STAGES-1];

endmodule

FILE: hdl/vau_div.sv
// three-lane pipelined restoring divider with final sign and clamp stage
module vau_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  vau_pkg::carry_t carry_i,
  output logic            valid_o,
  output vau_pkg::res_t   res_o
);
  import vau_pkg::*;

  localparam int unsigned DW = 32 + FRAC_BITS;
  localparam logic [DW-1:0] LIM = {{(DW-32){1'b0}}, 1'b1, 31'b0};

  logic                  v_q  [DW];
  carry_t                c_q  [DW];
  logic [2:0][DW-1:0]    nq_q [DW];
  logic [2:0][31:0]      rem_q[DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic               vi;
    carry_t             ci;
    logic [2:0][DW-1:0] ni;
    logic [2:0][31:0]   mi;
    logic [2:0][32:0]   sh;
    logic [2:0]         ge;

    if (k == 0) begin : g_first
      assign vi = valid_i;
      assign ci = carry_i;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign ni[i] = {abs32(carry_i.a[i]), {FRAC_BITS{1'b0}}};
        assign mi[i] = '0;
      end
    end else begin : g_next
      assign vi = v_q[k-1];
      assign ci = c_q[k-1];
      assign ni = nq_q[k-1];
      assign mi = rem_q[k-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_cmp
      assign sh[i] = {mi[i], ni[i][DW-1]};
      assign ge[i] = sh[i] >= {1'b0, ci.dvs[i]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k] <= ci;
        for (int i = 0; i < 3; i++) begin
          nq_q[k][i]  <= {ni[i][DW-2:0], ge[i]};
          rem_q[k][i] <= ge[i] ? 32'(sh[i] - {1'b0, ci.dvs[i]}) : sh[i][31:0];
        end
      end
    end
  end

  carry_t             cl;
  logic [2:0][DW-1:0] q;
  logic [2:0]         lane_sat;
  res_t               res_d, res_q;
  logic               vo_q;

  assign cl = c_q[DW-1];
  assign q  = nq_q[DW-1];

  always_comb begin
    res_d = cl.res;
    for (int i = 0; i < 3; i++) begin
      lane_sat[i] = cl.neg[i] ? (q[i] > LIM) : (q[i] >= LIM);
    end
    if (cl.use_div) begin
      for (int i = 0; i < 3; i++) begin
        if (lane_sat[i]) begin
          res_d.r[i] = cl.neg[i] ? FX_MIN : FX_MAX;
        end else begin
          res_d.r[i] = cl.neg[i] ? (~q[i][31:0] + 32'd1) : q[i][31:0];
        end
      end
      res_d.sat = |lane_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule

FILE: hdl/vector3_arithmetic_unit_top.sv
// throughput: one word per cycle while no output stall holds the pipe; set by the 32-stage
// square root and the (32 + FRAC_BITS)-stage dividers that every word passes through
// the input stays open during an output stall until the skid register holds a word
// reset clears valid bits only; no state survives between words
module vector3_arithmetic_unit_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [3:0]         command_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] az_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_comp_i,
  input  logic signed [31:0] bz_i,
  input  logic signed [31:0] scalar_in_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] rx_o,
  output logic signed [31:0] ry_o,
  output logic signed [31:0] rz_o,
  output logic signed [31:0] scalar_out_o,
  output logic               saturated_o
);
  import vau_pkg::*;

  logic             en;
  logic             fr_v, sq_v, dv_v;
  carry_t           fr_c, sq_c, ps_d, ps_q;
  logic             ps_v_q;
  logic [63:0]      rad;
  logic [31:0]      root;
  res_t             dv_r, out_q, skid_q;
  logic             out_v_q, skid_v_q, out_rdy;

  assign en = !skid_v_q;

  vau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (valid_i),
    .command_i (command_i),
    .a_i       ({az_i, ay_i, ax_i}),
    .b_i       ({bz_i, by_comp_i, bx_i}),
    .s_i       (scalar_in_i),
    .valid_o   (fr_v),
    .carry_o   (fr_c),
    .rad_o     (rad)
  );

  vau_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .carry_i (fr_c),
    .rad_i   (rad),
    .valid_o (sq_v),
    .carry_o (sq_c),
    .root_o  (root)
  );

  always_comb begin
    ps_d = sq_c;
    if (sq_c.is_len) begin
      ps_d.res.sc  = root[31] ? FX_MAX : root;
      ps_d.res.sat = root[31];
    end
    if (sq_c.is_norm) begin
      for (int i = 0; i < 3; i++) begin
        ps_d.dvs[i] = root;
        ps_d.neg[i] = sq_c.a[i][31];
      end
      ps_d.use_div = (root != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_v_q <= 1'b0;
    end else if (en) begin
      ps_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q <= ps_d;
    end
  end

  vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ps_v_q),
    .carry_i (ps_q),
    .valid_o (dv_v),
    .res_o   (dv_r)
  );

  // output register with skid
  assign out_rdy = !out_v_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_rdy) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (out_rdy) begin
      out_v_q <= dv_v;
    end else if (dv_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_rdy) begin
        out_q <= skid_q;
      end
    end else if (out_rdy) begin
      out_q <= dv_r;
    end else begin
      skid_q <= dv_r;
    end
  end

  assign stall_o      = skid_v_q;
  assign valid_o      = out_v_q;
  assign rx_o         = out_q.r[0];
  assign ry_o         = out_q.r[1];
  assign rz_o         = out_q.r[2];
  assign scalar_out_o = out_q.sc;
  assign saturated_o  = out_q.sat;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held without an output word");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && stall_i))
    else $error("skid filled while output was free");

  a_frozen_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(dv_v) && $stable(ps_v_q))
    else $error("pipeline moved while frozen");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturated_o) |->
      (out_q.r[0] == FX_MAX || out_q.r[0] == FX_MIN ||
       out_q.r[1] == FX_MAX || out_q.r[1] == FX_MIN ||
       out_q.r[2] == FX_MAX || out_q.r[2] == FX_MIN ||
       out_q.sc == FX_MAX || out_q.sc == FX_MIN))
    else $error("saturation flag without a clamped value");

endmodule

FILE: bench/vector3_arithmetic_unit_top_tb.sv
// testbench for the vector arithmetic unit: random and directed words checked against a predictor
`timescale 1ns / 1ps
module vector3_arithmetic_unit_top_tb;
  import vau_pkg::*;

  localparam int FB = 16;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [31:0] rx, ry, rz, sc;
    logic        sat;
  } vres_t;

  function automatic logic signed [31:0] clamp(input logic signed [127:0] v, ref logic flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] fdiv(input logic signed [127:0] n,
                                               input logic signed [127:0] d);
    logic signed [127:0] q;
    q = (n <<< FB) / d;
    return q;
  endfunction

  function automatic logic [63:0] root(input logic [127:0] n);
    logic [127:0] r, b;
    r = 0;
    b = 128'd1 << 126;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  function automatic vres_t vector_result(input logic [3:0] cmd,
                                          input logic signed [31:0] a[3],
                                          input logic signed [31:0] b[3],
                                          input logic signed [31:0] s);
    vres_t o;
    logic signed [127:0] av[3], bv[3], sv, t, len;
    logic signed [31:0] r[3];
    logic f;
    f = 1'b0;
    for (int i = 0; i < 3; i++) begin
      av[i] = a[i];
      bv[i] = b[i];
      r[i] = 0;
    end
    sv = s;
    o.sc = 0;
    case (cmd)
      CMD_ADD: for (int i = 0; i < 3; i++) r[i] = clamp(av[i] + bv[i], f);
      CMD_SUB: for (int i = 0; i < 3; i++) r[i] = clamp(av[i] - bv[i], f);
      CMD_MUL: for (int i = 0; i < 3; i++) r[i] = clamp((av[i] * bv[i]) >>> FB, f);
      CMD_DIV: begin
        if (b[0] == 0 || b[1] == 0 || b[2] == 0) begin
          for (int i = 0; i < 3; i++) r[i] = a[i];
        end else begin
          for (int i = 0; i < 3; i++) r[i] = clamp(fdiv(av[i], bv[i]), f);
        end
      end
      CMD_SADD: for (int i = 0; i < 3; i++) r[i] = clamp(av[i] + sv, f);
      CMD_SSUB: for (int i = 0; i < 3; i++) r[i] = clamp(av[i] - sv, f);
      CMD_SMUL: for (int i = 0; i < 3; i++) r[i] = clamp((av[i] * sv) >>> FB, f);
      CMD_SDIV: begin
        if (s == 0) begin
          for (int i = 0; i < 3; i++) r[i] = a[i];
        end else begin
          for (int i = 0; i < 3; i++) r[i] = clamp(fdiv(av[i], sv), f);
        end
      end
      CMD_DOT: begin
        t = av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2];
        o.sc = clamp(t >>> FB, f);
      end
      CMD_CROSS: begin
        r[0] = clamp((av[1] * bv[2] - av[2] * bv[1]) >>> FB, f);
        r[1] = clamp((av[2] * bv[0] - av[0] * bv[2]) >>> FB, f);
        r[2] = clamp((av[0] * bv[1] - av[1] * bv[0]) >>> FB, f);
      end
      CMD_LEN, CMD_NORM: begin
        len = {64'd0, root(av[0] * av[0] + av[1] * av[1] + av[2] * av[2])};
        if (cmd == CMD_LEN) begin
          o.sc = clamp(len, f);
        end else if (len != 0) begin
          for (int i = 0; i < 3; i++) r[i] = clamp(fdiv(av[i], len), f);
        end
      end
      default: ;
    endcase
    o.rx = r[0];
    o.ry = r[1];
    o.rz = r[2];
    o.sat = f;
    return o;
  endfunction

  class result_board;
    vres_t pending[$];
    int errors;
    int checked;

    function void note_word(input logic [3:0] cmd, input logic signed [31:0] a[3],
                            input logic signed [31:0] b[3], input logic signed [31:0] s);
      pending.push_back(vector_result(cmd, a, b, s));
    endfunction

    function void check_word(input logic [31:0] rx, ry, rz, sc, input logic sat);
      vres_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (rx !== e.rx) begin $error("rx expected %h got %h", e.rx, rx); errors++; end
      if (ry !== e.ry) begin $error("ry expected %h got %h", e.ry, ry); errors++; end
      if (rz !== e.rz) begin $error("rz expected %h got %h", e.rz, rz); errors++; end
      if (sc !== e.sc) begin
        $error("scalar_out expected %h got %h", e.sc, sc);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated expected %b got %b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, saturated_o;
  logic [3:0] command_i = '0;
  logic signed [31:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [31:0] bx_i = '0, by_comp_i = '0, bz_i = '0, scalar_in_i = '0;
  logic signed [31:0] rx_o, ry_o, rz_o, scalar_out_o;

  result_board board = new();
  int idle_cycles = 0;
  int sent = 0;
  bit timed_out = 0;
  bit sink_busy = 1;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  vector3_arithmetic_unit_top #(.FRAC_BITS(FB)) u_dut (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i)
        board.check_word(rx_o, ry_o, rz_o, scalar_out_o, saturated_o);
      if ((valid_o && !stall_i) || (valid_i && !stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("vector3_arithmetic_unit_top verification failed");
      $finish;
    end
  end

  // output stall pattern, calm stretches included
  initial begin
    int n;
    @(posedge rst_ni);
    while (sink_busy) begin
      n = gap_len();
      @(negedge clk_i);
      if (n != 0) begin
        stall_i <= ($urandom_range(0, 9) > 2);
        repeat (n) @(negedge clk_i);
        stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
    end
  end

  task automatic send_word(input logic [3:0] cmd, input logic signed [31:0] a[3],
                           input logic signed [31:0] b[3], input logic signed [31:0] s);
    int n;
    command_i <= cmd;
    ax_i <= a[0]; ay_i <= a[1]; az_i <= a[2];
    bx_i <= b[0]; by_comp_i <= b[1]; bz_i <= b[2];
    scalar_in_i <= s;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    board.note_word(cmd, a, b, s);
    sent++;
    @(negedge clk_i);
    n = gap_len();
    if (($urandom_range(0, 2) == 0) && (n != 0)) begin
      valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic signed [31:0] a[3], b[3], s;
    logic signed [31:0] ext[4];
    ext = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh10000};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // every command with extreme operands, zero divisors and zero vector included
    for (int c = 0; c < 16; c++) begin
      a = '{ext[c % 4], ext[(c + 1) % 4], ext[(c + 2) % 4]};
      b = '{ext[(c + 3) % 4], ext[c % 4], ext[(c + 1) % 4]};
      send_word(c[3:0], a, b, ext[(c + 2) % 4]);
    end
    a = '{0, 0, 0};
    send_word(CMD_NORM, a, a, 0);
    send_word(CMD_SDIV, '{32'sh10000, -5, 7}, a, 0);
    send_word(CMD_DIV, '{32'sh10000, -5, 7}, '{3, 0, 9}, 0);
    // hold off until the pipe drains
    valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    for (int k = 0; k < 1050; k++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_val();
        b[i] = rand_val();
      end
      s = rand_val();
      send_word(4'($urandom_range(0, 15)), a, b, s);
    end
    valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    sink_busy = 0;
    $display("sent %0d words over all sixteen command codes, %0d results checked",
             sent, board.checked);
    $display("random operands mixed extremes, zeros and small values with random stalls");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("vector3_arithmetic_unit_top verification clean");
    end else begin
      $display("vector3_arithmetic_unit_top verification failed");
    end
    $finish;
  end
endmodule

FILE: vector3_arithmetic_unit_top.f
hdl/vau_pkg.sv
hdl/vau_front.sv
hdl/vau_sqrt.sv
hdl/vau_div.sv
hdl/vector3_arithmetic_unit_top.sv
bench/vector3_arithmetic_unit_top_tb.sv
